// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros for the vertex transform block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/vtpd_pkg.sv =====
// ----------------------------------------------------------------------------
// vtpd_pkg
// Types and constants shared by the vertex transform and divide pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package vtpd_pkg;
    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = 3;
    localparam int REG_W     = 64;
    localparam int DATA_W    = 32;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic signed [31:0] in_w;
    } vtx_in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic               w_zero;
    } vtx_out_t;

    typedef enum logic [1:0] {
        WMODE_ONE  = 2'd0,
        WMODE_ZERO = 2'd1,
        WMODE_DIV  = 2'd2
    } wmode_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== hdl/vtpd_div.sv =====
// ----------------------------------------------------------------------------
// vtpd_div
// Pipelined signed divider: q = trunc(n / d), one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module vtpd_div #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 32,
    parameter int TAG_W = 1
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic signed [NUM_W-1:0] num,
    input  wire logic signed [DEN_W-1:0] den,
    input  wire logic [TAG_W-1:0]        tag_in,
    output logic                         out_valid,
    output logic signed [NUM_W:0]        quo,
    output logic [TAG_W-1:0]             tag_out
);
    localparam int N = NUM_W;
    localparam int R = DEN_W + 1;

    logic             v_reg   [0:N];
    logic [N-1:0]     q_reg   [0:N];
    logic [R-1:0]     r_reg   [0:N];
    logic [DEN_W-1:0] d_reg   [0:N];
    logic             neg_reg [0:N];
    logic [TAG_W-1:0] t_reg   [0:N];

    logic [N-1:0]     n_abs;
    logic [DEN_W-1:0] d_abs;
    logic [N:0]       n_ext;
    logic [DEN_W:0]   d_ext;

    always_comb
    begin
        n_ext = num[N-1] ? -{num[N-1], num} : {num[N-1], num};
        d_ext = den[DEN_W-1] ? -{den[DEN_W-1], den} : {den[DEN_W-1], den};
        n_abs = n_ext[N-1:0];
        d_abs = d_ext[DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= N; i++)
                v_reg[i] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= N; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0]   <= n_abs;
        r_reg[0]   <= '0;
        d_reg[0]   <= d_abs;
        neg_reg[0] <= num[N-1] ^ den[DEN_W-1];
        t_reg[0]   <= tag_in;
        for (int i = 1; i <= N; i++)
        begin
            logic [R:0] trial;
            logic [R:0] shifted;
            shifted = {r_reg[i-1], q_reg[i-1][N-1]};
            trial   = shifted - {2'b0, d_reg[i-1]};
            if (!trial[R])
            begin
                r_reg[i] <= trial[R-1:0];
                q_reg[i] <= {q_reg[i-1][N-2:0], 1'b1};
            end
            else
            begin
                r_reg[i] <= shifted[R-1:0];
                q_reg[i] <= {q_reg[i-1][N-2:0], 1'b0};
            end
            d_reg[i]   <= d_reg[i-1];
            neg_reg[i] <= neg_reg[i-1];
            t_reg[i]   <= t_reg[i-1];
        end
    end

    assign out_valid = v_reg[N];
    assign quo       = neg_reg[N] ? -{1'b0, q_reg[N]} : {1'b0, q_reg[N]};
    assign tag_out   = t_reg[N];
endmodule
`default_nettype wire

// ===== hdl/vertex_transform_perspective_divide_top.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide_top: 4x4 vertex transform, perspective divide
// Pipeline: 4 transform stages, 33+FRAC_BITS divider stages and one output register.
// Throughput: one item per cycle; busy stays low, each of x, y, z has its own divider.
// Reset clears all valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
`default_nettype none
module vertex_transform_perspective_divide_top
    import vtpd_pkg::*;
#(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire vtx_in_t              din,
    output logic                      done,
    output vtx_out_t                  dout,
    input  wire logic                 cfg_we,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0]     cfg_data
);
`include "assert_macros.svh"

    localparam logic [31:0] FX_ONE = 32'(1) << FRAC_BITS;
    localparam int PW   = COEF_WIDTH + 32;
    localparam int NUMW = 32 + FRAC_BITS;

    logic [REG_W-1:0] regs_reg [0:REG_COUNT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                regs_reg[i] <= '0;
            regs_reg[0] <= {32'd0, FX_ONE};
            regs_reg[2] <= {FX_ONE, 32'd0};
            regs_reg[5] <= {32'd0, FX_ONE};
            regs_reg[7] <= {FX_ONE, 32'd0};
        end
        else if (cfg_we)
            regs_reg[cfg_index] <= cfg_data;
    end

    function automatic logic signed [COEF_WIDTH-1:0] coef(input int r, input int c);
        logic [63:0] w;
        w = regs_reg[REG_IDX_W'(r*2 + c/2)];
        return (c % 2 == 1) ? w[32 +: COEF_WIDTH] : w[0 +: COEF_WIDTH];
    endfunction

    assign busy = 1'b0;

    // stage 1: register the vertex
    logic               s1_v_reg;
    logic signed [31:0] s1_vec_reg [0:3];
    // stage 2: products
    logic               s2_v_reg;
    logic signed [PW-1:0] s2_p_reg [0:3][0:3];
    // stage 3: pairwise sums
    logic               s3_v_reg;
    logic signed [PW+1:0] s3_s_reg [0:3][0:1];
    // stage 4: row sums shifted and saturated
    logic               s4_v_reg;
    logic signed [31:0] s4_t_reg [0:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= start;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_vec_reg[0] <= din.in_x;
        s1_vec_reg[1] <= din.in_y;
        s1_vec_reg[2] <= din.in_z;
        s1_vec_reg[3] <= din.in_w;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                s2_p_reg[r][c] <= PW'(coef(r, c) * s1_vec_reg[c]);
        for (int r = 0; r < 4; r++)
        begin
            s3_s_reg[r][0] <= (PW+2)'(s2_p_reg[r][0]) + (PW+2)'(s2_p_reg[r][1]);
            s3_s_reg[r][1] <= (PW+2)'(s2_p_reg[r][2]) + (PW+2)'(s2_p_reg[r][3]);
        end
        for (int r = 0; r < 4; r++)
        begin
            logic signed [PW+2:0] sum;
            logic signed [PW+2:0] sh;
            sum = (PW+3)'(s3_s_reg[r][0]) + (PW+3)'(s3_s_reg[r][1]);
            sh  = sum >>> FRAC_BITS;
            s4_t_reg[r] <= sat32(64'(sh));
        end
    end

    // classify w and feed dividers
    wmode_t s4_mode;
    always_comb
    begin
        if (s4_t_reg[3] == FX_ONE)
            s4_mode = WMODE_ONE;
        else if (s4_t_reg[3] == 32'sd0)
            s4_mode = WMODE_ZERO;
        else
            s4_mode = WMODE_DIV;
    end

    localparam int TAGW = 2 + 4*32;
    logic [TAGW-1:0] tag_in;
    assign tag_in = {s4_mode, s4_t_reg[0], s4_t_reg[1], s4_t_reg[2], s4_t_reg[3]};

    logic                dv   [0:2];
    logic signed [NUMW:0] q   [0:2];
    logic [TAGW-1:0]     tg   [0:2];

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_div
            vtpd_div #(.NUM_W(NUMW), .DEN_W(32), .TAG_W(TAGW)) u_div (
                .clk      (clk),
                .rst_n    (rst_n),
                .in_valid (s4_v_reg),
                .num      (NUMW'(s4_t_reg[g]) <<< FRAC_BITS),
                .den      (s4_t_reg[3]),
                .tag_in   (tag_in),
                .out_valid(dv[g]),
                .quo      (q[g]),
                .tag_out  (tg[g])
            );
        end
    endgenerate

    wmode_t o_mode;
    logic signed [31:0] o_t [0:3];
    assign o_mode = wmode_t'(tg[0][TAGW-1 -: 2]);
    assign o_t[0] = tg[0][127:96];
    assign o_t[1] = tg[0][95:64];
    assign o_t[2] = tg[0][63:32];
    assign o_t[3] = tg[0][31:0];

    logic     done_reg;
    vtx_out_t dout_reg;
    vtx_out_t dout_next;

    always_comb
    begin
        dout_next.out_x  = o_t[0];
        dout_next.out_y  = o_t[1];
        dout_next.out_z  = o_t[2];
        dout_next.out_w  = o_t[3];
        dout_next.w_zero = 1'b0;
        case (o_mode)
            WMODE_ZERO: dout_next.w_zero = 1'b1;
            WMODE_DIV:
            begin
                dout_next.out_x = sat32(64'(q[0]));
                dout_next.out_y = sat32(64'(q[1]));
                dout_next.out_z = sat32(64'(q[2]));
                dout_next.out_w = FX_ONE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv[0];
    end

    always_ff @(posedge clk)
        dout_reg <= dout_next;

    assign done = done_reg;
    assign dout = dout_reg;

    `ASSERT_IMPL(a_lanes_agree, clk, rst_n, 1'b1, (dv[0] == dv[1]) && (dv[1] == dv[2]), "divider lanes out of step")
    `ASSERT_IMPL(a_tags_agree, clk, rst_n, dv[0], (tg[0] == tg[1]) && (tg[1] == tg[2]), "divider tags differ")
    `ASSERT_NEXT(a_done_follows, clk, rst_n, dv[0], done, "done lost")
    `ASSERT_IMPL(a_wzero_flag, clk, rst_n, done && dout.w_zero, dout.out_w == 32'sd0, "w_zero with nonzero w")
endmodule
`default_nettype wire
